// ----- design/sorted_key_table_search_insert_defines.svh -----
// Assertion macros for the sorted key table search/insert block.
`ifndef SORTED_KEY_TABLE_SEARCH_INSERT_DEFINES_SVH
`define SORTED_KEY_TABLE_SEARCH_INSERT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SKT_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sorted key table assertion failed");

// Next-cycle implication, checked outside reset.
`define SKT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sorted key table assertion failed");

`endif

// ----- design/skt_pkg.sv -----
// Shared types for the sorted key table search/insert block.
package skt_pkg;

   // Result status codes
   typedef enum logic [2:0] {
      ST_NOT_FOUND = 3'd0,
      ST_FOUND     = 3'd1,
      ST_NEW       = 3'd2,
      ST_COLLISION = 3'd3,
      ST_FULL      = 3'd4
   } status_type;

   // Controller states
   typedef enum logic [3:0] {
      S_IDLE,
      S_PROBE,
      S_STEP,
      S_CHECK,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_INSERT,
      S_DONE
   } state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic       load;
      logic       probe_rd;
      logic       probe_upd;
      logic       chk_rd;
      logic       shift_rd;
      logic       shift_wr;
      logic       ins_wr;
      logic       rsp_load;
      status_type rsp_code;
   } cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic search_open;
      logic pos_in;
      logic hit;
      logic create;
      logic excl;
      logic full;
      logic shift_more;
   } stat_type;

endpackage

// ----- design/skt_if.sv -----
// Request and response channel interfaces.
interface skt_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] search_key;
   logic               create;
   logic               exclusive;
   modport source (output valid, output search_key, output create, output exclusive,
                   input ready);
   modport sink (input valid, input search_key, input create, input exclusive,
                 output ready);
endinterface

interface skt_rsp_if import skt_pkg::*; ;
   logic       valid;
   logic       ready;
   status_type status;
   logic [7:0] slot;
   logic [8:0] entry_count;
   modport source (output valid, output status, output slot, output entry_count,
                   input ready);
   modport sink (input valid, input status, input slot, input entry_count,
                 output ready);
endinterface

// ----- design/sorted_key_table_search_insert.sv -----
// Top level of the sorted key table search/insert block.
// Holds up to TABLE_DEPTH signed 32-bit keys in ascending order, no duplicates.
// Request channel (req_ch): search_key, create, exclusive; one transfer per request.
// Response channel (rsp_ch): status, slot, entry_count; one transfer per request.
// A request is taken only when the block is idle; its response sits in an
// output register, so the next request is taken while that response waits.
// Steps: the binary search makes each probe through the single read port of
// the key memory, then a final compare reads the key at the found position;
// an insert then moves each larger key up one slot and writes the new key;
// last the response is loaded into the output register.
// The block does not take a new request until it has returned to idle.
// Reset clears the key count and the control state; the key memory keeps its
// contents, which are never read before they are written.
// If the receiver stalls, the response holds and a finished next request waits
// in its final state until the output register frees up.
`include "sorted_key_table_search_insert_defines.svh"
module sorted_key_table_search_insert import skt_pkg::*; #(
   parameter int TABLE_DEPTH = 256
) (
   input logic   clock,
   input logic   reset,
   skt_req_if.sink   req_ch,
   skt_rsp_if.source rsp_ch
);

   cmd_type  cmd;
   stat_type stat;

   // Controller
   skt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Datapath
   skt_datapath #(.TABLE_DEPTH(TABLE_DEPTH)) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_key         (req_ch.search_key),
      .req_create      (req_ch.create),
      .req_exclusive   (req_ch.exclusive),
      .rsp_status      (rsp_ch.status),
      .rsp_slot        (rsp_ch.slot),
      .rsp_entry_count (rsp_ch.entry_count)
   );

   // Checks
   `SKT_ASSERT_NEXT(a_busy_after_req, clock, reset, req_ch.valid && req_ch.ready, !req_ch.ready)
   `SKT_ASSERT_NOW(a_slot_zero, clock, reset, rsp_ch.valid && (rsp_ch.status == ST_NOT_FOUND || rsp_ch.status == ST_COLLISION || rsp_ch.status == ST_FULL), rsp_ch.slot == 8'd0)
   `SKT_ASSERT_NOW(a_full_count, clock, reset, rsp_ch.valid && rsp_ch.status == ST_FULL, rsp_ch.entry_count == 9'(TABLE_DEPTH))
   `SKT_ASSERT_NEXT(a_load_while_idle, clock, reset, cmd.load, !req_ch.ready)

endmodule

// ----- design/skt_ctrl.sv -----
// Controller state machine: binary search, ordered shift and response handoff.
module skt_ctrl import skt_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type  state_ff, state_in;
   status_type code_ff, code_in;
   logic       rsp_valid_ff, rsp_valid_in;

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         code_ff      <= ST_NOT_FOUND;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         code_ff      <= code_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in     = state_ff;
      code_in      = code_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      cmd.rsp_code = code_ff;
      req_ready    = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_PROBE;
            end
         end
         S_PROBE: begin
            if (stat.search_open) begin
               cmd.probe_rd = 1'b1;
               state_in     = S_STEP;
            end else begin
               cmd.chk_rd = stat.pos_in;
               state_in   = S_CHECK;
            end
         end
         S_STEP: begin
            cmd.probe_upd = 1'b1;
            state_in      = S_PROBE;
         end
         S_CHECK: begin
            if (stat.hit) begin
               code_in  = stat.excl ? ST_COLLISION : ST_FOUND;
               state_in = S_DONE;
            end else if (!stat.create) begin
               code_in  = ST_NOT_FOUND;
               state_in = S_DONE;
            end else if (stat.full) begin
               code_in  = ST_FULL;
               state_in = S_DONE;
            end else begin
               state_in = S_SHIFT_RD;
            end
         end
         S_SHIFT_RD: begin
            if (stat.shift_more) begin
               cmd.shift_rd = 1'b1;
               state_in     = S_SHIFT_WR;
            end else begin
               state_in = S_INSERT;
            end
         end
         S_SHIFT_WR: begin
            cmd.shift_wr = 1'b1;
            state_in     = S_SHIFT_RD;
         end
         S_INSERT: begin
            cmd.ins_wr = 1'b1;
            code_in    = ST_NEW;
            state_in   = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- design/skt_datapath.sv -----
// Datapath: key memory, search bounds, shift index and response registers.
module skt_datapath import skt_pkg::*; #(
   parameter int TABLE_DEPTH = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output stat_type           stat,
   input  logic signed [31:0] req_key,
   input  logic               req_create,
   input  logic               req_exclusive,
   output status_type         rsp_status,
   output logic [7:0]         rsp_slot,
   output logic [8:0]         rsp_entry_count
);

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   logic signed [31:0] key_mem [TABLE_DEPTH];

   logic signed [31:0] key_ff, rd_ff;
   logic               create_ff, excl_ff;
   logic [CW-1:0]      lo_ff, hi_ff, mid_ff, idx_ff, count_ff;
   logic [CW-1:0]      mid, idx_dec;
   logic [AW-1:0]      rd_addr, wr_addr;
   logic               rd_en, wr_en;
   logic signed [31:0] wr_data;
   status_type         status_ff;
   logic [7:0]         slot_ff;
   logic [8:0]         count_out_ff;
   logic [CW+7:0]      lo_ext;
   logic [CW+8:0]      cnt_ext;

   assign mid     = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign idx_dec = idx_ff - CW'(1);

   // Memory port selection
   assign rd_en   = cmd.probe_rd || cmd.chk_rd || cmd.shift_rd;
   assign rd_addr = cmd.probe_rd ? mid[AW-1:0] :
                    cmd.chk_rd   ? lo_ff[AW-1:0] : idx_dec[AW-1:0];
   assign wr_en   = cmd.shift_wr || cmd.ins_wr;
   assign wr_addr = cmd.shift_wr ? idx_ff[AW-1:0] : lo_ff[AW-1:0];
   assign wr_data = cmd.shift_wr ? rd_ff : key_ff;

   // Key memory, registered read
   always_ff @(posedge clock) begin
      if (wr_en) key_mem[wr_addr] <= wr_data;
      if (rd_en) rd_ff <= key_mem[rd_addr];
   end

   // Entry count
   always_ff @(posedge clock) begin
      if (reset) count_ff <= '0;
      else if (cmd.ins_wr) count_ff <= count_ff + CW'(1);
   end

   // Search bounds, shift index and request capture
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         key_ff    <= req_key;
         create_ff <= req_create;
         excl_ff   <= req_exclusive;
         lo_ff     <= '0;
         hi_ff     <= count_ff;
         idx_ff    <= count_ff;
      end
      if (cmd.probe_rd) mid_ff <= mid;
      if (cmd.probe_upd) begin
         if (rd_ff < key_ff) lo_ff <= mid_ff + CW'(1);
         else hi_ff <= mid_ff;
      end
      if (cmd.shift_wr) idx_ff <= idx_dec;
   end

   // Status to controller
   assign stat.search_open = lo_ff < hi_ff;
   assign stat.pos_in      = lo_ff < count_ff;
   assign stat.hit         = (lo_ff < count_ff) && (rd_ff == key_ff);
   assign stat.create      = create_ff;
   assign stat.excl        = excl_ff;
   assign stat.full        = count_ff == CW'(TABLE_DEPTH);
   assign stat.shift_more  = idx_ff > lo_ff;

   // Response payload
   assign lo_ext  = {8'b0, lo_ff};
   assign cnt_ext = {9'b0, count_ff};

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         status_ff    <= cmd.rsp_code;
         slot_ff      <= (cmd.rsp_code == ST_FOUND || cmd.rsp_code == ST_NEW) ?
                         lo_ext[7:0] : 8'd0;
         count_out_ff <= cnt_ext[8:0];
      end
   end

   assign rsp_status      = status_ff;
   assign rsp_slot        = slot_ff;
   assign rsp_entry_count = count_out_ff;

endmodule

// ----- tb/sv/skt_tb_checker.sv -----
// Response checker for the sorted key table: predicts each result and compares it.
module skt_tb_checker import skt_pkg::*; #(
   parameter int TABLE_DEPTH = 256
) (
   input  logic  clock,
   input  logic  reset,
   input  logic  req_valid,
   input  logic  req_ready,
   input  logic signed [31:0] req_key,
   input  logic  req_create,
   input  logic  req_excl,
   input  logic  rsp_valid,
   input  logic  rsp_ready,
   input  logic [2:0] rsp_status,
   input  logic [7:0] rsp_slot,
   input  logic [8:0] rsp_count,
   output int    fail_count,
   output int    pending_count,
   output int    result_count,
   output int    insert_count,
   output int    full_count
);

   typedef struct packed {
      status_type status;
      logic [7:0] slot;
      logic [8:0] entry_count;
   } lookup_result_type;

   // Predicted copy of the sorted table
   logic signed [31:0] shadow_keys [TABLE_DEPTH];
   int                 shadow_count;
   lookup_result_type  expected_results [$];

   // Apply one request to the shadow table and return its result
   function automatic lookup_result_type predict_lookup(logic signed [31:0] key, logic create,
                                                        logic excl);
      lookup_result_type r;
      int pos;
      pos = 0;
      while (pos < shadow_count && shadow_keys[pos] < key) pos++;
      r.slot = '0;
      if (pos < shadow_count && shadow_keys[pos] == key) begin
         if (excl) r.status = ST_COLLISION;
         else begin
            r.status = ST_FOUND;
            r.slot = pos[7:0];
         end
      end else if (!create) begin
         r.status = ST_NOT_FOUND;
      end else if (shadow_count >= TABLE_DEPTH) begin
         r.status = ST_FULL;
      end else begin
         for (int i = shadow_count; i > pos; i--) shadow_keys[i] = shadow_keys[i-1];
         shadow_keys[pos] = key;
         shadow_count++;
         r.status = ST_NEW;
         r.slot = pos[7:0];
      end
      r.entry_count = shadow_count[8:0];
      return r;
   endfunction

   // Watch both channels at each rising edge
   always @(posedge clock) begin
      lookup_result_type want;
      bit                mismatch;
      if (reset) begin
         shadow_count = 0;
         expected_results.delete();
         fail_count <= 0;
         pending_count <= 0;
         result_count <= 0;
         insert_count <= 0;
         full_count <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            result_count <= result_count + 1;
            if (expected_results.size() == 0) begin
               $error("result transfer with no request outstanding");
               fail_count <= fail_count + 1;
            end else begin
               want = expected_results.pop_front();
               mismatch = 1'b0;
               if (want.status == ST_NEW) insert_count <= insert_count + 1;
               if (want.status == ST_FULL) full_count <= full_count + 1;
               if (rsp_status != want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_status);
                  mismatch = 1'b1;
               end
               if (rsp_slot != want.slot) begin
                  $error("slot: expected %0d, got %0d", want.slot, rsp_slot);
                  mismatch = 1'b1;
               end
               if (rsp_count != want.entry_count) begin
                  $error("entry_count: expected %0d, got %0d", want.entry_count,
                         rsp_count);
                  mismatch = 1'b1;
               end
               if (mismatch) fail_count <= fail_count + 1;
            end
         end
         if (req_valid && req_ready)
            expected_results.push_back(predict_lookup(req_key, req_create, req_excl));
         pending_count <= expected_results.size();
      end
   end

endmodule

// ----- tb/sv/tb_top.sv -----
// Testbench top for the sorted key table: stimulus, clock, reset and verdict.
module tb_top;

   localparam int TABLE_DEPTH = 256;
   localparam int RANDOM_REQUESTS = 430;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count, pending_count, result_count, insert_count, full_count;
   int   stall_hold = 0;
   bit   idle_enable = 1'b1;

   skt_req_if req_ch ();
   skt_rsp_if rsp_ch ();

   sorted_key_table_search_insert #(.TABLE_DEPTH(TABLE_DEPTH)) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   skt_tb_checker #(.TABLE_DEPTH(TABLE_DEPTH)) i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_ch.valid),
      .req_ready     (req_ch.ready),
      .req_key       (req_ch.search_key),
      .req_create    (req_ch.create),
      .req_excl      (req_ch.exclusive),
      .rsp_valid     (rsp_ch.valid),
      .rsp_ready     (rsp_ch.ready),
      .rsp_status    (rsp_ch.status),
      .rsp_slot      (rsp_ch.slot),
      .rsp_count     (rsp_ch.entry_count),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .result_count  (result_count),
      .insert_count  (insert_count),
      .full_count    (full_count)
   );

   always #5 clock = ~clock;

   // Run limit: reports a fail and ends the run if the test hangs
   initial begin
      #20000000;
      $display("status: fail");
      $finish;
   end

   // Keys used so far, so that random requests revisit them
   logic signed [31:0] key_pool [$];

   // Offer one request and hold it until the transfer happens
   task automatic send_request(logic signed [31:0] key, logic create, logic excl);
      while (idle_enable && $urandom_range(99) < 14) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.search_key <= key;
      req_ch.create     <= create;
      req_ch.exclusive  <= excl;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      @(negedge clock);
      key_pool.push_back(key);
   endtask

   function automatic logic signed [31:0] pick_key();
      int sel;
      sel = $urandom_range(9);
      if (sel < 5 && key_pool.size() > 0)
         return key_pool[$urandom_range(key_pool.size() - 1)];
      else if (sel < 7)
         return $signed($urandom_range(64)) - 32;
      else
         return $urandom;
   endfunction

   // Receiver: random stalls, plus one long hold-off when asked
   always @(negedge clock) begin
      if (reset) rsp_ch.ready <= 1'b0;
      else if (stall_hold > 0) begin
         rsp_ch.ready <= 1'b0;
         stall_hold <= stall_hold - 1;
      end else rsp_ch.ready <= !(idle_enable && $urandom_range(99) < 14);
   end

   initial begin
      int drain_cycles;
      req_ch.valid      = 1'b0;
      req_ch.search_key = '0;
      req_ch.create     = 1'b0;
      req_ch.exclusive  = 1'b0;
      rsp_ch.ready      = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: empty table, extremes of the key, every status but table full
      send_request(32'sh7fffffff, 1'b0, 1'b0);
      send_request(32'sh7fffffff, 1'b1, 1'b0);
      send_request(32'sh80000000, 1'b1, 1'b1);
      send_request(32'sh00000000, 1'b1, 1'b0);
      send_request(-32'sd1, 1'b1, 1'b0);
      send_request(32'sd1, 1'b1, 1'b0);
      send_request(32'sh80000000, 1'b0, 1'b0);
      send_request(32'sh7fffffff, 1'b1, 1'b1);
      send_request(32'sh00000000, 1'b0, 1'b1);
      send_request(-32'sd1, 1'b1, 1'b0);
      send_request(32'sh55555555, 1'b0, 1'b0);
      send_request(32'shaaaaaaaa, 1'b1, 1'b0);
      send_request(32'sh55555555, 1'b1, 1'b1);

      // Long receiver hold-off while requests keep coming
      stall_hold = 200;
      for (int i = 0; i < 6; i++) send_request(pick_key(), 1'b1, 1'($urandom_range(1)));

      // Random mix; a quiet stretch with no idling in the middle
      for (int i = 0; i < RANDOM_REQUESTS; i++) begin
         idle_enable = !(i >= 150 && i < 230);
         send_request(pick_key(), $urandom_range(9) < 7, $urandom_range(3) == 0);
      end
      idle_enable = 1'b1;

      // Fill the table and hit the full case
      while (i_checker.shadow_count < TABLE_DEPTH) send_request($urandom, 1'b1, 1'b0);
      for (int i = 0; i < 8; i++) send_request(pick_key(), 1'($urandom_range(1)),
                                               1'($urandom_range(1)));
      send_request(32'sh12345678 ^ $urandom, 1'b1, 1'b0);
      req_ch.valid <= 1'b0;

      drain_cycles = 0;
      while (pending_count > 0 && drain_cycles < 200000) begin
         @(posedge clock);
         drain_cycles++;
      end
      repeat (600) @(posedge clock);
      $display("covered %0d results, %0d inserts, %0d table-full reports",
               result_count, insert_count, full_count);
      if (fail_count == 0 && pending_count == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

endmodule
